// ===== src/apu_pkg.sv =====
// Package for the Adam parameter update block: widths, reset values,
// configuration register codes. Used by the other files under src.
`default_nettype none
package apu_pkg;

    localparam int APU_PARAM_COUNT = 4096;
    localparam int APU_IDX_W       = 12;
    localparam int APU_DATA_W      = 32;
    localparam int APU_CFG_IDX_W   = 2;

    // defaults for the pipelined arithmetic units
    localparam int APU_DEF_DW   = 33;
    localparam int APU_DEF_QW   = 32;
    localparam int APU_DEF_SW   = 1;
    localparam int APU_ROOT_W   = 32;

    localparam logic [31:0] APU_LR_RST   = 32'd4294967;
    localparam logic [31:0] APU_B1_RST   = 32'd3865470566;
    localparam logic [31:0] APU_B2_RST   = 32'd4290672329;
    localparam logic [31:0] APU_EPS_RST  = 32'd43;
    localparam logic [32:0] APU_ONE_Q32  = 33'h1_0000_0000;

    typedef enum logic [APU_CFG_IDX_W-1:0] {
        CFG_LEARN_RATE = 2'd0,
        CFG_BETA_ONE   = 2'd1,
        CFG_BETA_TWO   = 2'd2,
        CFG_EPSILON    = 2'd3
    } t_cfg_reg;

endpackage
`default_nettype wire

// ===== src/apu_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side word
// that travels alongside. Depends on apu_pkg for default widths.
`default_nettype none
module apu_div_pipe #(
    parameter int DW = apu_pkg::APU_DEF_DW,
    parameter int QW = apu_pkg::APU_DEF_QW,
    parameter int SW = apu_pkg::APU_DEF_SW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_rem,   // must be below i_den for a valid quotient
    input  wire logic [QW-1:0] i_num,   // dividend bits shifted in, msb first
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    logic [DW-1:0] s_rem  [QW];
    logic [DW-1:0] s_den  [QW];
    logic [QW-1:0] s_num  [QW];
    logic [QW-1:0] s_quo  [QW];
    logic [SW-1:0] s_side [QW];
    logic [QW-1:0] s_vld;

    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_num [QW];
    logic [QW-1:0] n_quo [QW];

    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_num  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_vld;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] w_rem2;
        logic [DW:0] w_diff;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign s_rem[k]  = i_rem;
            assign s_den[k]  = i_den;
            assign s_num[k]  = i_num;
            assign s_quo[k]  = '0;
            assign s_side[k] = i_side;
            assign s_vld[k]  = i_valid;
        end else begin : g_next
            assign s_rem[k]  = r_rem[k-1];
            assign s_den[k]  = r_den[k-1];
            assign s_num[k]  = r_num[k-1];
            assign s_quo[k]  = r_quo[k-1];
            assign s_side[k] = r_side[k-1];
            assign s_vld[k]  = r_vld[k-1];
        end

        assign w_rem2   = {s_rem[k], s_num[k][QW-1]};
        assign w_diff   = w_rem2 - {1'b0, s_den[k]};
        assign w_ge     = (w_rem2 >= {1'b0, s_den[k]});
        assign n_rem[k] = w_ge ? w_diff[DW-1:0] : w_rem2[DW-1:0];
        assign n_num[k] = {s_num[k][QW-2:0], 1'b0};
        assign n_quo[k] = {s_quo[k][QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= s_den[k];
                r_num[k]  <= n_num[k];
                r_quo[k]  <= n_quo[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

// ===== src/apu_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage, with a side word.
// Depends on apu_pkg for default widths.
`default_nettype none
module apu_sqrt_pipe #(
    parameter int RW = apu_pkg::APU_ROOT_W,
    parameter int SW = apu_pkg::APU_DEF_SW
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*RW-1:0] i_x,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic [RW-1:0]        o_root,
    output logic [SW-1:0]        o_side
);

    localparam int REMW = RW + 3;

    logic [2*RW-1:0] s_x    [RW];
    logic [REMW-1:0] s_rem  [RW];
    logic [RW-1:0]   s_root [RW];
    logic [SW-1:0]   s_side [RW];
    logic [RW-1:0]   s_vld;

    logic [2*RW-1:0] n_x    [RW];
    logic [REMW-1:0] n_rem  [RW];
    logic [RW-1:0]   n_root [RW];

    logic [2*RW-1:0] r_x    [RW];
    logic [REMW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [SW-1:0]   r_side [RW];
    logic [RW-1:0]   r_vld;

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [REMW-1:0] w_sh;
        logic [REMW-1:0] w_trial;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign s_x[k]    = i_x;
            assign s_rem[k]  = '0;
            assign s_root[k] = '0;
            assign s_side[k] = i_side;
            assign s_vld[k]  = i_valid;
        end else begin : g_next
            assign s_x[k]    = r_x[k-1];
            assign s_rem[k]  = r_rem[k-1];
            assign s_root[k] = r_root[k-1];
            assign s_side[k] = r_side[k-1];
            assign s_vld[k]  = r_vld[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_sh      = {s_rem[k][REMW-3:0], s_x[k][2*RW-1 -: 2]};
        assign w_trial   = {1'b0, s_root[k], 2'b01};
        assign w_ge      = (w_sh >= w_trial);
        assign n_rem[k]  = w_ge ? (w_sh - w_trial) : w_sh;
        assign n_root[k] = {s_root[k][RW-2:0], w_ge};
        assign n_x[k]    = {s_x[k][2*RW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_x[k]    <= n_x[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule
`default_nettype wire

// ===== src/adam_parameter_update_top.sv =====
// Adam optimizer parameter update, top level: moment memories, beta powers,
// moment update stage and the divide / root pipeline.
// Depends on apu_pkg, apu_div_pipe and apu_sqrt_pipe.
//
//  channel  | direction | handshake                    | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | index, weight, gradient; tuser new_step
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | out_index, new_weight
//  cfg      | in        | i_cfg_wr_en                  | i_cfg_index, i_cfg_data
//
// One word accepted per cycle while the pipe does not stall; a result passes
// 3 setup stages, 32 + 48 + 34 divider stages, 32 root stages and 2 more.
// The per-index moment read-modify-write closes in one stage, so words with
// the same index may follow back to back.
// After reset the moment memories are cleared entry by entry; no word is
// accepted meanwhile. When the output word is held, the whole pipe stalls.
`default_nettype none
module adam_parameter_update_top #(
    parameter int PARAM_COUNT = apu_pkg::APU_PARAM_COUNT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [79:0]                         s_axis_tdata,  // param_index, weight, gradient
    input  wire logic                                s_axis_tuser,  // new_step
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [47:0]                              m_axis_tdata,  // out_index, new_weight
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [apu_pkg::APU_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [apu_pkg::APU_DATA_W-1:0]      i_cfg_data
);
    import apu_pkg::*;

    localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

    typedef struct packed {
        logic [11:0] idx;
        logic [31:0] w;
        logic        inr;
        logic        mneg;
        logic        m_raw;
        logic        m_sat;
        logic [31:0] mmag;
        logic [31:0] v;
        logic [32:0] c2;
    } t_s1;

    typedef struct packed {
        logic [11:0] idx;
        logic [31:0] w;
        logic        inr;
        logic        mneg;
        logic [31:0] mhat;
        logic        v_raw;
        logic        v_sat;
        logic [31:0] v;
    } t_s2;

    typedef struct packed {
        logic [11:0] idx;
        logic [31:0] w;
        logic        inr;
        logic        mneg;
        logic [31:0] mhat;
    } t_s3;

    typedef struct packed {
        logic [11:0] idx;
        logic [31:0] w;
        logic        inr;
        logic        mneg;
        logic        sat;
    } t_s4;

    // configuration
    logic [31:0] r_lr, r_b1, r_b2, r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= APU_LR_RST;
            r_b1  <= APU_B1_RST;
            r_b2  <= APU_B2_RST;
            r_eps <= APU_EPS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LEARN_RATE: r_lr  <= i_cfg_data;
                CFG_BETA_ONE:   r_b1  <= i_cfg_data;
                CFG_BETA_TWO:   r_b2  <= i_cfg_data;
                CFG_EPSILON:    r_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control
    logic          r_clearing;
    logic [AW-1:0] r_clr_cnt;
    logic          r_o_valid;
    logic          en;
    logic          accept;

    assign en            = !r_o_valid || m_axis_tready;
    assign s_axis_tready = en && !r_clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(PARAM_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // beta powers advance on the first word of each step
    logic [32:0] r_p1, r_p2, n_p1, n_p2;
    logic [64:0] w_p1_prod, w_p2_prod;

    assign w_p1_prod = 65'(r_p1) * 65'(r_b1);
    assign w_p2_prod = 65'(r_p2) * 65'(r_b2);

    always_comb begin
        n_p1 = r_p1;
        n_p2 = r_p2;
        if (accept && s_axis_tuser) begin
            n_p1 = w_p1_prod[64:32];
            n_p2 = w_p2_prod[64:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= APU_ONE_Q32;
            r_p2 <= APU_ONE_Q32;
        end else begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
    end

    // stage P: input word, bias correction divisors
    logic        r_p_valid;
    logic [11:0] r_p_idx;
    logic [31:0] r_p_w, r_p_g;
    logic [32:0] r_p_c1, r_p_c2;
    logic        r_p_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_idx <= s_axis_tdata[11:0];
            r_p_w   <= s_axis_tdata[43:12];
            r_p_g   <= s_axis_tdata[75:44];
            r_p_c1  <= APU_ONE_Q32 - n_p1;
            r_p_c2  <= APU_ONE_Q32 - n_p2;
            r_p_inr <= (32'(s_axis_tdata[11:0]) < 32'(PARAM_COUNT));
        end
    end

    logic [31:0] w_gmag, w_g2;
    logic [63:0] w_g2_full;

    assign w_gmag    = r_p_g[31] ? (~r_p_g + 32'd1) : r_p_g;
    assign w_g2_full = 64'(w_gmag) * 64'(w_gmag);
    assign w_g2      = (|w_g2_full[63:48]) ? 32'hFFFF_FFFF : w_g2_full[47:16];

    // stage A: moment read-modify-write
    logic        r_a_valid;
    logic [11:0] r_a_idx;
    logic [31:0] r_a_w, r_a_g, r_a_g2;
    logic [32:0] r_a_c1, r_a_c2;
    logic        r_a_inr;

    logic [31:0] r_first_mom  [PARAM_COUNT];
    logic [31:0] r_second_mom [PARAM_COUNT];
    logic [31:0] r_m_rd, r_v_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_idx <= r_p_idx;
            r_a_w   <= r_p_w;
            r_a_g   <= r_p_g;
            r_a_g2  <= w_g2;
            r_a_c1  <= r_p_c1;
            r_a_c2  <= r_p_c2;
            r_a_inr <= r_p_inr;
        end
    end

    logic        r_b_valid;
    logic [11:0] r_b_idx;
    logic [31:0] r_b_w, r_b_m, r_b_v;
    logic [32:0] r_b_c1, r_b_c2;
    logic        r_b_inr;

    logic               w_fwd;
    logic [31:0]        w_m_cur, w_v_cur, w_m_new, w_v_new;
    logic signed [32:0] w_d1, w_d2;
    logic signed [33:0] w_k1, w_k2;
    logic signed [66:0] w_prod1, w_prod2;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_wa;
    logic [31:0]        w_mem_wm, w_mem_wv;

    // the word one stage ahead writes on the same edge this one reads
    assign w_fwd   = r_b_valid && r_b_inr && (r_b_idx == r_a_idx);
    assign w_m_cur = w_fwd ? r_b_m : r_m_rd;
    assign w_v_cur = w_fwd ? r_b_v : r_v_rd;

    // new = cur + floor((1 - beta) * (x - cur))
    assign w_d1    = $signed({r_a_g[31], r_a_g}) - $signed({w_m_cur[31], w_m_cur});
    assign w_d2    = $signed({1'b0, r_a_g2}) - $signed({1'b0, w_v_cur});
    assign w_k1    = $signed({1'b0, APU_ONE_Q32 - {1'b0, r_b1}});
    assign w_k2    = $signed({1'b0, APU_ONE_Q32 - {1'b0, r_b2}});
    assign w_prod1 = w_d1 * w_k1;
    assign w_prod2 = w_d2 * w_k2;
    assign w_m_new = w_m_cur + w_prod1[63:32];
    assign w_v_new = w_v_cur + w_prod2[63:32];

    assign w_mem_we = r_clearing || (en && r_a_valid && r_a_inr);
    assign w_mem_wa = r_clearing ? r_clr_cnt : AW'(r_a_idx);
    assign w_mem_wm = r_clearing ? 32'd0 : w_m_new;
    assign w_mem_wv = r_clearing ? 32'd0 : w_v_new;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_first_mom[w_mem_wa]  <= w_mem_wm;
            r_second_mom[w_mem_wa] <= w_mem_wv;
        end
        if (en) begin
            r_m_rd <= r_first_mom[AW'(r_p_idx)];
            r_v_rd <= r_second_mom[AW'(r_p_idx)];
        end
    end

    // stage B: new moments
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_idx <= r_a_idx;
            r_b_w   <= r_a_w;
            r_b_m   <= w_m_new;
            r_b_v   <= w_v_new;
            r_b_c1  <= r_a_c1;
            r_b_c2  <= r_a_c2;
            r_b_inr <= r_a_inr;
        end
    end

    logic [31:0] w_mmag;
    t_s1         w_s1_in, w_s1_out;
    logic [31:0] w_q1;
    logic        w_d1_valid;

    assign w_mmag = r_b_m[31] ? (~r_b_m + 32'd1) : r_b_m;

    always_comb begin
        w_s1_in.idx   = r_b_idx;
        w_s1_in.w     = r_b_w;
        w_s1_in.inr   = r_b_inr;
        w_s1_in.mneg  = r_b_m[31];
        w_s1_in.m_raw = (r_b_c1 == 33'd0);
        w_s1_in.m_sat = ({1'b0, w_mmag} >= r_b_c1);
        w_s1_in.mmag  = w_mmag;
        w_s1_in.v     = r_b_v;
        w_s1_in.c2    = r_b_c2;
    end

    // mhat = |m| / (1 - beta_one^t)
    apu_div_pipe #(
        .DW(33),
        .QW(32),
        .SW($bits(t_s1))
    ) u_div_mhat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_rem   ({1'b0, w_mmag}),
        .i_num   (32'd0),
        .i_den   (r_b_c1),
        .i_side  (w_s1_in),
        .o_valid (w_d1_valid),
        .o_quo   (w_q1),
        .o_side  (w_s1_out)
    );

    t_s2         w_s2_in, w_s2_out;
    logic [47:0] w_q2;
    logic        w_d2_valid;

    always_comb begin
        w_s2_in.idx   = w_s1_out.idx;
        w_s2_in.w     = w_s1_out.w;
        w_s2_in.inr   = w_s1_out.inr;
        w_s2_in.mneg  = w_s1_out.mneg;
        if (w_s1_out.m_raw) begin
            w_s2_in.mhat = w_s1_out.mmag;
        end else if (w_s1_out.m_sat) begin
            w_s2_in.mhat = 32'hFFFF_FFFF;
        end else begin
            w_s2_in.mhat = w_q1;
        end
        w_s2_in.v_raw = (w_s1_out.c2 == 33'd0);
        w_s2_in.v_sat = ({17'd0, w_s1_out.v[31:16]} >= w_s1_out.c2);
        w_s2_in.v     = w_s1_out.v;
    end

    // vhat = v / (1 - beta_two^t), 48 quotient bits
    apu_div_pipe #(
        .DW(33),
        .QW(48),
        .SW($bits(t_s2))
    ) u_div_vhat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_d1_valid),
        .i_rem   ({17'd0, w_s1_out.v[31:16]}),
        .i_num   ({w_s1_out.v[15:0], 32'd0}),
        .i_den   (w_s1_out.c2),
        .i_side  (w_s2_in),
        .o_valid (w_d2_valid),
        .o_quo   (w_q2),
        .o_side  (w_s2_out)
    );

    logic [47:0] w_vhat;
    t_s3         w_s3_in, w_s3_out;
    logic [31:0] w_root;
    logic        w_sq_valid;

    always_comb begin
        if (w_s2_out.v_raw) begin
            w_vhat = {16'd0, w_s2_out.v};
        end else if (w_s2_out.v_sat) begin
            w_vhat = 48'hFFFF_FFFF_FFFF;
        end else begin
            w_vhat = w_q2;
        end
        w_s3_in.idx  = w_s2_out.idx;
        w_s3_in.w    = w_s2_out.w;
        w_s3_in.inr  = w_s2_out.inr;
        w_s3_in.mneg = w_s2_out.mneg;
        w_s3_in.mhat = w_s2_out.mhat;
    end

    apu_sqrt_pipe #(
        .RW(32),
        .SW($bits(t_s3))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_d2_valid),
        .i_x     ({w_vhat, 16'd0}),
        .i_side  (w_s3_in),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_s3_out)
    );

    // stage N: denominator and numerator of the step
    logic        r_n_valid;
    logic [48:0] r_n_den;
    logic [63:0] r_n_num;
    t_s3         r_n_side;
    logic [48:0] w_den;

    assign w_den = {1'b0, w_root, 16'd0} + {17'd0, r_eps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (en) begin
            r_n_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_den  <= (w_den == 49'd0) ? 49'd1 : w_den;
            r_n_num  <= 64'(w_s3_out.mhat) * 64'(r_lr);
            r_n_side <= w_s3_out;
        end
    end

    t_s4         w_s4_in, w_s4_out;
    logic [33:0] w_q3;
    logic        w_d3_valid;

    always_comb begin
        w_s4_in.idx  = r_n_side.idx;
        w_s4_in.w    = r_n_side.w;
        w_s4_in.inr  = r_n_side.inr;
        w_s4_in.mneg = r_n_side.mneg;
        w_s4_in.sat  = ({19'd0, r_n_num[63:34]} >= r_n_den);
    end

    apu_div_pipe #(
        .DW(49),
        .QW(34),
        .SW($bits(t_s4))
    ) u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_n_valid),
        .i_rem   ({19'd0, r_n_num[63:34]}),
        .i_num   (r_n_num[33:0]),
        .i_den   (r_n_den),
        .i_side  (w_s4_in),
        .o_valid (w_d3_valid),
        .o_quo   (w_q3),
        .o_side  (w_s4_out)
    );

    // final add, saturate, output word
    logic [34:0]        w_step;
    logic signed [35:0] w_w36, w_sum;
    logic [31:0]        w_nw;

    always_comb begin
        if (w_s4_out.sat || (w_q3 > 34'h2_0000_0000)) begin
            w_step = 35'h2_0000_0000;
        end else begin
            w_step = {1'b0, w_q3};
        end
        w_w36 = $signed({{4{w_s4_out.w[31]}}, w_s4_out.w});
        if (w_s4_out.mneg) begin
            w_sum = w_w36 + $signed({1'b0, w_step});
        end else begin
            w_sum = w_w36 - $signed({1'b0, w_step});
        end
        if (!w_s4_out.inr) begin
            w_nw = w_s4_out.w;
        end else if (w_sum > 36'sh0_7FFF_FFFF) begin
            w_nw = 32'h7FFF_FFFF;
        end else if (w_sum < -36'sh0_8000_0000) begin
            w_nw = 32'h8000_0000;
        end else begin
            w_nw = w_sum[31:0];
        end
    end

    logic [11:0] r_o_idx;
    logic [31:0] r_o_nw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= w_d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_idx <= w_s4_out.idx;
            r_o_nw  <= w_nw;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {4'd0, r_o_nw, r_o_idx};

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !s_axis_tready)
        else $error("word accepted during moment clear");

    a_no_pipe_write_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_a_valid)
        else $error("moment update during clear");

    a_p1_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1 <= APU_ONE_Q32)
        else $error("beta_one power above one");

    a_p2_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2 <= APU_ONE_Q32)
        else $error("beta_two power above one");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for adam_parameter_update_top: streams words, checks each result
// against a scoreboard that predicts the Adam update. Depends on apu_pkg.
`timescale 1ns / 1ps

import apu_pkg::*;

typedef struct {
    logic [11:0] idx;
    logic [31:0] weight;
} t_upd;

class adam_sb;
    t_upd            pending[$];
    int              errors;
    int              m_mem [4096];
    logic [31:0]     v_mem [4096];
    longint unsigned b1_pow, b2_pow;
    logic [31:0]     lr, b1, b2, eps;

    function void init();
        errors = 0;
        foreach (m_mem[i]) begin
            m_mem[i] = 0;
            v_mem[i] = 0;
        end
        b1_pow = 64'h1_0000_0000;
        b2_pow = 64'h1_0000_0000;
        lr  = APU_LR_RST;
        b1  = APU_B1_RST;
        b2  = APU_B2_RST;
        eps = APU_EPS_RST;
    endfunction

    function void write_reg(t_cfg_reg r, logic [31:0] d);
        case (r)
            CFG_LEARN_RATE: lr  = d;
            CFG_BETA_ONE:   b1  = d;
            CFG_BETA_TWO:   b2  = d;
            CFG_EPSILON:    eps = d;
            default: ;
        endcase
    endfunction

    function longint unsigned isqrt(longint unsigned x);
        longint unsigned r, bt;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function void note_word(logic [11:0] idx, logic [31:0] w, logic [31:0] g,
                            logic new_step);
        longint          wl, gl, s, mn, nw, b1l;
        longint unsigned gmag, g2, vn, mmag, mhat, vhat, c1, c2, den, stp;
        bit              mneg;
        t_upd            e;
        wl  = longint'($signed(w));
        gl  = longint'($signed(g));
        b1l = longint'({32'b0, b1});
        if (new_step) begin
            b1_pow = (b1_pow * b1) >> 32;
            b2_pow = (b2_pow * b2) >> 32;
        end
        s  = b1l * longint'(m_mem[idx]) + (64'sh1_0000_0000 - b1l) * gl;
        mn = s >>> 32;
        gmag = (gl < 0) ? -gl : gl;
        g2   = (gmag * gmag) >> 16;
        if (g2 > 64'hFFFF_FFFF) g2 = 64'hFFFF_FFFF;
        vn = (longint'({32'b0, b2}) * longint'({32'b0, v_mem[idx]})
              + (64'h1_0000_0000 - b2) * g2) >> 32;
        m_mem[idx] = int'(mn);
        v_mem[idx] = vn[31:0];
        mneg = mn < 0;
        mmag = mneg ? -mn : mn;
        c1 = 64'h1_0000_0000 - b1_pow;
        c2 = 64'h1_0000_0000 - b2_pow;
        // no bias correction while a power is still exactly one
        mhat = (c1 == 0) ? mmag : (mmag << 32) / c1;
        if (mhat > 64'hFFFF_FFFF) mhat = 64'hFFFF_FFFF;
        vhat = (c2 == 0) ? vn : (vn << 32) / c2;
        if (vhat > 64'hFFFF_FFFF_FFFF) vhat = 64'hFFFF_FFFF_FFFF;
        den = (isqrt(vhat << 16) << 16) + eps;
        if (den == 0) den = 1;
        stp = (mhat * lr) / den;
        if (stp > (64'd1 << 33)) stp = 64'd1 << 33;
        nw = mneg ? wl + longint'(stp) : wl - longint'(stp);
        if (nw > 64'sh7FFF_FFFF) nw = 64'sh7FFF_FFFF;
        if (nw < -64'sh8000_0000) nw = -64'sh8000_0000;
        e.idx    = idx;
        e.weight = nw[31:0];
        pending.push_back(e);
    endfunction

    function void check_word(logic [47:0] d);
        t_upd e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word idx=%0d weight=%h", $time, d[11:0], d[43:12]);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[11:0] !== e.idx) begin
            $display("%0t: out_index exp %0d got %0d", $time, e.idx, d[11:0]);
            errors++;
        end
        if (d[43:12] !== e.weight) begin
            $display("%0t: new_weight exp %h got %h (idx %0d)", $time, e.weight,
                     d[43:12], e.idx);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [79:0] s_axis_tdata;   // param_index, weight, gradient
    logic        m_axis_tvalid, m_axis_tready;
    logic [47:0] m_axis_tdata;   // out_index, new_weight
    logic        i_cfg_wr_en;
    logic [APU_CFG_IDX_W-1:0] i_cfg_index;
    logic [APU_DATA_W-1:0]    i_cfg_data;

    localparam int STALL_LIMIT = 20000;

    adam_sb      sb;
    bit          no_idle;
    int          stall_cnt;
    logic [11:0] idx_pool [8];

    adam_parameter_update_top dut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver
    always @(negedge i_clk)
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(logic [11:0] idx, logic [31:0] w, logic [31:0] g,
                             logic ns);
        while (!no_idle && $urandom_range(99) < 26) begin
            s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata  = {4'b0, g, w, idx};
        s_axis_tuser  = ns;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(idx, w, g, ns);
        @(negedge i_clk);
        s_axis_tvalid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, logic [31:0] d);
        i_cfg_wr_en = 1;
        i_cfg_index = r;
        i_cfg_data  = d;
        sb.write_reg(r, d);
        @(negedge i_clk);
        i_cfg_wr_en = 0;
    endtask

    task automatic set_cfg(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2,
                           logic [31:0] e);
        drain();
        write_reg(CFG_LEARN_RATE, lr);
        write_reg(CFG_BETA_ONE, b1);
        write_reg(CFG_BETA_TWO, b2);
        write_reg(CFG_EPSILON, e);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097151)) - 1048576);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(131071)) - 65536);
        endcase
    endfunction

    task automatic random_run(int n);
        logic [11:0] idx;
        foreach (idx_pool[i]) idx_pool[i] = $urandom;
        repeat (n) begin
            idx = ($urandom_range(99) < 80) ? idx_pool[$urandom_range(7)] : 12'($urandom);
            send_word(idx, rand_val(), rand_val(), $urandom_range(15) == 0);
        end
    endtask

    initial begin
        sb = new();
        sb.init();
        no_idle       = 0;
        stall_cnt     = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 0;
        m_axis_tready = 0;
        i_cfg_wr_en   = 0;
        i_cfg_index   = CFG_LEARN_RATE;
        i_cfg_data    = '0;
        i_rst_n       = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: powers still one for the first words, so their moments go uncorrected
        send_word(12'd0, 32'h0001_0000, 32'h0000_8000, 0);
        send_word(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_word(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_word(12'd1, 32'h8000_0000, 32'h8000_0000, 1);
        send_word(12'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_word(12'd2, 32'h0, 32'h0, 1);
        send_word(12'd0, 32'hFFFF_FFFF, 32'hFFFF_0000, 0);
        send_word(12'd0, 32'h0, 32'h0, 0);
        // zero denominator: no epsilon and an untouched second moment
        set_cfg(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_word(12'd100, 32'h0, 32'h0, 0);
        send_word(12'd101, 32'h1234_5678, 32'h0, 1);
        send_word(12'd102, 32'h0, 32'h0000_0001, 0);
        send_word(12'd103, 32'h0, 32'hFFFF_FFFF, 0);
        send_word(12'd104, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        set_cfg(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(12'd200, 32'h0, 32'h7FFF_FFFF, 1);
        send_word(12'd200, 32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_word(12'd200, 32'hAAAA_AAAA, 32'h5555_5555, 1);

        set_cfg(APU_LR_RST, APU_B1_RST, APU_B2_RST, APU_EPS_RST);
        random_run(100);
        // no idling on either side for a while
        no_idle = 1;
        random_run(100);
        no_idle = 0;
        set_cfg(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        random_run(90);
        set_cfg($urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_run(90);
        set_cfg($urandom, $urandom, $urandom, $urandom);
        random_run(80);
        set_cfg(32'h0, $urandom, $urandom, 32'h0);
        random_run(70);

        drain();
        repeat (160) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== adam_parameter_update_top.f =====
src/apu_pkg.sv
src/apu_div_pipe.sv
src/apu_sqrt_pipe.sv
src/adam_parameter_update_top.sv
tb/tb.sv
